// ----- hdl/dct_coef_runlength_vlc_encoder_macros.svh -----
// Assertion shorthands used by the encoder top level.
`ifndef DCT_COEF_RUNLENGTH_VLC_ENCODER_MACROS_SVH
`define DCT_COEF_RUNLENGTH_VLC_ENCODER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define DCRLV_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define DCRLV_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/dcrlv_pkg.sv -----
package dcrlv_pkg;

  // Packer word width default
  localparam int WORD_BITS_DEF = 32;

  // Field widths
  localparam int COEF_W     = 12;
  localparam int OUT_WORD_W = 32;
  localparam int VBITS_W    = 6;
  localparam int POS_W      = 6;
  localparam int THR_W      = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_THR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_START = 2'd2;

  localparam logic [THR_W-1:0] LUMA_THR_RST     = 8'd1;
  localparam logic [THR_W-1:0] CHROMA_THR_RST   = 8'd2;
  localparam logic [POS_W-1:0] FILTER_START_RST = 6'd20;

  // Opcodes
  localparam logic OP_COEF  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Symbol: one item's code bits, right aligned (code plus end of block)
  localparam int CODE_W = 22;
  localparam int LEN_W  = 5;

  localparam int ESC_W = 20;
  localparam logic [5:0]       ESC_PREFIX = 6'b000001;
  localparam logic [LEN_W-1:0] ESC_LEN    = 5'd20;
  localparam logic [1:0]       EOB_CODE   = 2'b10;
  localparam logic [LEN_W-1:0] EOB_LEN    = 5'd2;
  localparam logic [LEN_W-1:0] DC_LEN     = 5'd8;
  localparam logic [POS_W-1:0] LAST_POS   = 6'd63;

  // Symbol queue between classifier and packer (depth a power of two)
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic                     opcode;
    logic signed [COEF_W-1:0] coef;
    logic                     is_chroma;
  } in_item_t;

  typedef struct packed {
    logic [OUT_WORD_W-1:0] word;
    logic [VBITS_W-1:0]    valid_bits;
    logic                  from_flush;
  } out_item_t;

  typedef struct packed {
    logic              flush;
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } sym_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       hit;
    logic [5:0] code;
    logic [3:0] len;
  } vlc_t;

  // TCOEFF run/level table; code without sign bit, len without sign bit
  function automatic vlc_t vlc_lookup(input logic [5:0] run, input logic [3:0] mag);
    vlc_t r;
    r = '0;
    case ({run, mag})
      {6'd0, 4'd1}:   r = {1'b1, 6'h03, 4'd2};
      {6'd0, 4'd2}:   r = {1'b1, 6'h04, 4'd4};
      {6'd0, 4'd3}:   r = {1'b1, 6'h05, 4'd5};
      {6'd0, 4'd4}:   r = {1'b1, 6'h06, 4'd7};
      {6'd0, 4'd5}:   r = {1'b1, 6'h26, 4'd8};
      {6'd0, 4'd6}:   r = {1'b1, 6'h21, 4'd8};
      {6'd0, 4'd7}:   r = {1'b1, 6'h0A, 4'd10};
      {6'd0, 4'd8}:   r = {1'b1, 6'h1D, 4'd12};
      {6'd0, 4'd9}:   r = {1'b1, 6'h18, 4'd12};
      {6'd0, 4'd10}:  r = {1'b1, 6'h13, 4'd12};
      {6'd0, 4'd11}:  r = {1'b1, 6'h10, 4'd12};
      {6'd0, 4'd12}:  r = {1'b1, 6'h1A, 4'd13};
      {6'd0, 4'd13}:  r = {1'b1, 6'h19, 4'd13};
      {6'd0, 4'd14}:  r = {1'b1, 6'h18, 4'd13};
      {6'd0, 4'd15}:  r = {1'b1, 6'h17, 4'd13};
      {6'd1, 4'd1}:   r = {1'b1, 6'h03, 4'd3};
      {6'd1, 4'd2}:   r = {1'b1, 6'h06, 4'd6};
      {6'd1, 4'd3}:   r = {1'b1, 6'h25, 4'd8};
      {6'd1, 4'd4}:   r = {1'b1, 6'h0C, 4'd10};
      {6'd1, 4'd5}:   r = {1'b1, 6'h1B, 4'd12};
      {6'd1, 4'd6}:   r = {1'b1, 6'h16, 4'd13};
      {6'd1, 4'd7}:   r = {1'b1, 6'h15, 4'd13};
      {6'd2, 4'd1}:   r = {1'b1, 6'h05, 4'd4};
      {6'd2, 4'd2}:   r = {1'b1, 6'h04, 4'd7};
      {6'd2, 4'd3}:   r = {1'b1, 6'h0B, 4'd10};
      {6'd2, 4'd4}:   r = {1'b1, 6'h14, 4'd12};
      {6'd2, 4'd5}:   r = {1'b1, 6'h14, 4'd13};
      {6'd3, 4'd1}:   r = {1'b1, 6'h07, 4'd5};
      {6'd3, 4'd2}:   r = {1'b1, 6'h24, 4'd8};
      {6'd3, 4'd3}:   r = {1'b1, 6'h1C, 4'd12};
      {6'd3, 4'd4}:   r = {1'b1, 6'h13, 4'd13};
      {6'd4, 4'd1}:   r = {1'b1, 6'h06, 4'd5};
      {6'd4, 4'd2}:   r = {1'b1, 6'h0F, 4'd10};
      {6'd4, 4'd3}:   r = {1'b1, 6'h12, 4'd12};
      {6'd5, 4'd1}:   r = {1'b1, 6'h07, 4'd6};
      {6'd5, 4'd2}:   r = {1'b1, 6'h09, 4'd10};
      {6'd5, 4'd3}:   r = {1'b1, 6'h12, 4'd13};
      {6'd6, 4'd1}:   r = {1'b1, 6'h05, 4'd6};
      {6'd6, 4'd2}:   r = {1'b1, 6'h1E, 4'd12};
      {6'd7, 4'd1}:   r = {1'b1, 6'h04, 4'd6};
      {6'd7, 4'd2}:   r = {1'b1, 6'h15, 4'd12};
      {6'd8, 4'd1}:   r = {1'b1, 6'h07, 4'd7};
      {6'd8, 4'd2}:   r = {1'b1, 6'h11, 4'd12};
      {6'd9, 4'd1}:   r = {1'b1, 6'h05, 4'd7};
      {6'd9, 4'd2}:   r = {1'b1, 6'h11, 4'd13};
      {6'd10, 4'd1}:  r = {1'b1, 6'h27, 4'd8};
      {6'd10, 4'd2}:  r = {1'b1, 6'h10, 4'd13};
      {6'd11, 4'd1}:  r = {1'b1, 6'h23, 4'd8};
      {6'd12, 4'd1}:  r = {1'b1, 6'h22, 4'd8};
      {6'd13, 4'd1}:  r = {1'b1, 6'h20, 4'd8};
      {6'd14, 4'd1}:  r = {1'b1, 6'h0E, 4'd10};
      {6'd15, 4'd1}:  r = {1'b1, 6'h0D, 4'd10};
      {6'd16, 4'd1}:  r = {1'b1, 6'h08, 4'd10};
      {6'd17, 4'd1}:  r = {1'b1, 6'h1F, 4'd12};
      {6'd18, 4'd1}:  r = {1'b1, 6'h1A, 4'd12};
      {6'd19, 4'd1}:  r = {1'b1, 6'h19, 4'd12};
      {6'd20, 4'd1}:  r = {1'b1, 6'h17, 4'd12};
      {6'd21, 4'd1}:  r = {1'b1, 6'h16, 4'd12};
      {6'd22, 4'd1}:  r = {1'b1, 6'h1F, 4'd13};
      {6'd23, 4'd1}:  r = {1'b1, 6'h1E, 4'd13};
      {6'd24, 4'd1}:  r = {1'b1, 6'h1D, 4'd13};
      {6'd25, 4'd1}:  r = {1'b1, 6'h1C, 4'd13};
      {6'd26, 4'd1}:  r = {1'b1, 6'h1B, 4'd13};
      default:        r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/dct_coef_runlength_vlc_encoder.sv -----
// Channel  | Handshake            | Beat
// ---------+----------------------+-------------------------------------------
// in       | in_valid / in_ready  | in_data: opcode, coef, is_chroma
// out      | out_valid / out_ready| out_data: word, valid_bits, from_flush
// cfg      | cfg_we               | cfg_index, cfg_data (write only)
//
// One beat is accepted per cycle; the classifier turns it into a code symbol in
// the same cycle and the packer merges one symbol per cycle from a two-entry
// queue. A result passes through the queue and the output register before it is
// driven on out. in_ready falls only when the symbol queue is full, which happens
// when the output register is stalled by out_ready. Reset is synchronous and
// restores the configuration registers, the block position and an empty packer.
`include "dct_coef_runlength_vlc_encoder_macros.svh"

module dct_coef_runlength_vlc_encoder import dcrlv_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data
);

  sym_t    push_sym, head;
  logic    q_push, q_pop;
  q_stat_t q_stat;

  // Classify coefficients into code symbols
  dcrlv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .sym_push  (q_push),
    .sym       (push_sym)
  );

  // Decouple classifier and packer
  dcrlv_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_sym (push_sym),
    .pop      (q_pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // Pack symbols into words
  dcrlv_packer #(
    .WORD_BITS (WORD_BITS)
  ) u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `DCRLV_ASSERT_IMP(a_flush_partial, clk, rst_n, out_valid && out_data.from_flush,
    32'(out_data.valid_bits) < WORD_BITS, "flush beat reports a full word")
  `DCRLV_ASSERT_IMP(a_full_count, clk, rst_n, out_valid && !out_data.from_flush,
    out_data.valid_bits == 6'(WORD_BITS % 64), "word beat with partial count")
  `DCRLV_ASSERT_NXT(a_queue_fill, clk, rst_n, in_valid && in_ready && q_stat.empty && !q_pop,
    !q_stat.empty, "accepted beat lost before queue")

endmodule

// ----- hdl/dcrlv_front.sv -----
module dcrlv_front import dcrlv_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  input  q_stat_t               q_stat,
  output logic                  sym_push,
  output sym_t                  sym
);

  logic [THR_W-1:0] luma_thr_r, chroma_thr_r;
  logic [POS_W-1:0] fstart_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [5:0]       run_r, run_nxt;

  logic             accept;
  logic [COEF_W-1:0] c;
  logic [COEF_W:0]  c_ext;
  logic [COEF_W:0]  dc_t;
  logic [9:0]       dc_q;
  logic [7:0]       dc_val;
  logic [COEF_W:0]  mag;
  logic [7:0]       amp, amag;
  logic [THR_W-1:0] thr;
  logic             filt, lvl_zero, last, short_code;
  vlc_t             vlc;
  logic [ESC_W-1:0] code_bits;
  logic [LEN_W-1:0] code_len;
  logic [CODE_W-1:0] base_bits;
  logic [LEN_W-1:0] base_len;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign sym_push = accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      luma_thr_r   <= LUMA_THR_RST;
      chroma_thr_r <= CHROMA_THR_RST;
      fstart_r     <= FILTER_START_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LUMA_THR:     luma_thr_r   <= cfg_data[THR_W-1:0];
        REG_CHROMA_THR:   chroma_thr_r <= cfg_data[THR_W-1:0];
        REG_FILTER_START: fstart_r     <= cfg_data[POS_W-1:0];
        default:          ;
      endcase
    end
  end

  // DC rounding and clamp
  always_comb begin
    c     = in_data.coef;
    c_ext = {c[COEF_W-1], c};
    dc_t  = c_ext + 13'd4;
    dc_q  = dc_t[COEF_W:3];
    if (dc_t[COEF_W] || dc_q == 10'd0) begin
      dc_val = 8'd1;
    end else if (dc_q > 10'd254) begin
      dc_val = 8'd254;
    end else if (dc_q == 10'd128) begin
      dc_val = 8'd255;
    end else begin
      dc_val = dc_q[7:0];
    end
  end

  // AC level, threshold filter and code lookup
  always_comb begin
    mag        = c[COEF_W-1] ? (13'd0 - c_ext) : c_ext;
    amp        = c[7:0];
    amag       = amp[7] ? (8'd0 - amp) : amp;
    thr        = in_data.is_chroma ? chroma_thr_r : luma_thr_r;
    filt       = (pos_r >= fstart_r) && (mag <= {5'd0, thr});
    lvl_zero   = filt || (amp == 8'd0);
    last       = (pos_r == LAST_POS);
    vlc        = vlc_lookup(run_r, amag[3:0]);
    short_code = (amag[7:4] == 4'd0) && vlc.hit;
    if (short_code) begin
      code_bits = ESC_W'({vlc.code, amp[7]});
      code_len  = LEN_W'(vlc.len) + 5'd1;
    end else begin
      code_bits = {ESC_PREFIX, run_r, amp};
      code_len  = ESC_LEN;
    end
    base_bits = lvl_zero ? '0 : CODE_W'(code_bits);
    base_len  = lvl_zero ? '0 : code_len;
  end

  // Build the symbol for the queue
  always_comb begin
    sym = '0;
    if (in_data.opcode == OP_FLUSH) begin
      sym.flush = 1'b1;
    end else if (pos_r == '0) begin
      sym.bits = CODE_W'(dc_val);
      sym.len  = DC_LEN;
    end else if (last) begin
      sym.bits = {base_bits[CODE_W-3:0], EOB_CODE};
      sym.len  = base_len + EOB_LEN;
    end else begin
      sym.bits = base_bits;
      sym.len  = base_len;
    end
  end

  // Advance block position and zero run
  always_comb begin
    pos_nxt = pos_r;
    run_nxt = run_r;
    if (accept && in_data.opcode == OP_COEF) begin
      if (pos_r == '0) begin
        pos_nxt = 6'd1;
        run_nxt = '0;
      end else if (last) begin
        pos_nxt = '0;
        run_nxt = '0;
      end else begin
        pos_nxt = pos_r + 6'd1;
        run_nxt = lvl_zero ? run_r + 6'd1 : 6'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      run_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      run_r <= run_nxt;
    end
  end

endmodule

// ----- hdl/dcrlv_queue.sv -----
module dcrlv_queue import dcrlv_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  sym_t    push_sym,
  input  logic    pop,
  output sym_t    head,
  output q_stat_t q_stat
);

  sym_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (count_r == '0);

  // Store the pushed symbol
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_sym;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ----- hdl/dcrlv_packer.sv -----
module dcrlv_packer import dcrlv_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  sym_t      head,
  input  q_stat_t   q_stat,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int WIN_W  = WORD_BITS + CODE_W;
  localparam int FILL_W = $clog2(WORD_BITS);
  localparam int TOT_W  = $clog2(WIN_W);
  localparam int SH_W   = $clog2(WIN_W + 1);
  localparam logic [VBITS_W-1:0] FULL_CNT = VBITS_W'(WORD_BITS % 64);

  logic [WORD_BITS-1:0] accum_r, accum_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic [TOT_W-1:0]     total;
  logic [SH_W-1:0]      shamt;
  logic [WIN_W-1:0]     win;
  logic [WORD_BITS-1:0] word_full;
  logic                 full_word, emit, slot_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Merge the symbol into the bit window
  always_comb begin
    total     = TOT_W'(fill_r) + TOT_W'(head.len);
    shamt     = SH_W'(WIN_W) - SH_W'(total);
    win       = {accum_r, {CODE_W{1'b0}}} | (WIN_W'(head.bits) << shamt);
    word_full = win[WIN_W-1:CODE_W];
    full_word = (total >= TOT_W'(WORD_BITS));
    emit      = head.flush || full_word;
    slot_free = !out_valid_r || out_ready;
    pop       = !q_stat.empty && (!emit || slot_free);
  end

  // Next packer state and output beat
  always_comb begin
    accum_nxt     = accum_r;
    fill_nxt      = fill_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (pop) begin
      if (head.flush) begin
        out_data_nxt.word       = accum_r[OUT_WORD_W-1:0];
        out_data_nxt.valid_bits = VBITS_W'(fill_r);
        out_data_nxt.from_flush = 1'b1;
        out_valid_nxt           = 1'b1;
        accum_nxt               = '0;
        fill_nxt                = '0;
      end else if (full_word) begin
        out_data_nxt.word       = word_full[OUT_WORD_W-1:0];
        out_data_nxt.valid_bits = FULL_CNT;
        out_data_nxt.from_flush = 1'b0;
        out_valid_nxt           = 1'b1;
        accum_nxt = {win[CODE_W-1:0], {(WORD_BITS-CODE_W){1'b0}}};
        fill_nxt  = FILL_W'(total - TOT_W'(WORD_BITS));
      end else begin
        accum_nxt = word_full;
        fill_nxt  = FILL_W'(total);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      accum_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      accum_r     <= accum_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- tb/tb_dct_coef_runlength_vlc_encoder.sv -----
module tb_dct_coef_runlength_vlc_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  import dcrlv_pkg::*;

  // Index with no register behind it; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum {MIX_TYPICAL, MIX_ESCAPES} coef_mix_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;

  // Encoder state as the stream should leave it
  logic [THR_W-1:0] luma_thr_m = LUMA_THR_RST;
  logic [THR_W-1:0] chroma_thr_m = CHROMA_THR_RST;
  logic [POS_W-1:0] fstart_m = FILTER_START_RST;
  logic [31:0]      accum_m = '0;
  int               fill_m = 0;
  int               run_m = 0;
  int               pos_m = 0;
  bit               word_done;
  logic [31:0]      done_word;

  out_item_t        expected_words[$];
  out_item_t        next_word;

  int error_count = 0;
  int beats_sent = 0;
  int flushes_sent = 0;
  int words_checked = 0;
  int input_stall_cycles = 0;
  int reg_writes = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int rx_hold = 0;

  dct_coef_runlength_vlc_encoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // TCOEFF run/level codes, keyed run*100+mag; returns {code, len}, len 0 on miss
  function automatic logic [12:0] tcoeff_lookup(input int run, input int mag);
    logic [12:0] cl;
    case (run * 100 + mag)
      1:    cl = {8'h03, 5'd2};   2:    cl = {8'h04, 5'd4};
      3:    cl = {8'h05, 5'd5};   4:    cl = {8'h06, 5'd7};
      5:    cl = {8'h26, 5'd8};   6:    cl = {8'h21, 5'd8};
      7:    cl = {8'h0A, 5'd10};  8:    cl = {8'h1D, 5'd12};
      9:    cl = {8'h18, 5'd12};  10:   cl = {8'h13, 5'd12};
      11:   cl = {8'h10, 5'd12};  12:   cl = {8'h1A, 5'd13};
      13:   cl = {8'h19, 5'd13};  14:   cl = {8'h18, 5'd13};
      15:   cl = {8'h17, 5'd13};
      101:  cl = {8'h03, 5'd3};   102:  cl = {8'h06, 5'd6};
      103:  cl = {8'h25, 5'd8};   104:  cl = {8'h0C, 5'd10};
      105:  cl = {8'h1B, 5'd12};  106:  cl = {8'h16, 5'd13};
      107:  cl = {8'h15, 5'd13};
      201:  cl = {8'h05, 5'd4};   202:  cl = {8'h04, 5'd7};
      203:  cl = {8'h0B, 5'd10};  204:  cl = {8'h14, 5'd12};
      205:  cl = {8'h14, 5'd13};
      301:  cl = {8'h07, 5'd5};   302:  cl = {8'h24, 5'd8};
      303:  cl = {8'h1C, 5'd12};  304:  cl = {8'h13, 5'd13};
      401:  cl = {8'h06, 5'd5};   402:  cl = {8'h0F, 5'd10};
      403:  cl = {8'h12, 5'd12};
      501:  cl = {8'h07, 5'd6};   502:  cl = {8'h09, 5'd10};
      503:  cl = {8'h12, 5'd13};
      601:  cl = {8'h05, 5'd6};   602:  cl = {8'h1E, 5'd12};
      701:  cl = {8'h04, 5'd6};   702:  cl = {8'h15, 5'd12};
      801:  cl = {8'h07, 5'd7};   802:  cl = {8'h11, 5'd12};
      901:  cl = {8'h05, 5'd7};   902:  cl = {8'h11, 5'd13};
      1001: cl = {8'h27, 5'd8};   1002: cl = {8'h10, 5'd13};
      1101: cl = {8'h23, 5'd8};   1201: cl = {8'h22, 5'd8};
      1301: cl = {8'h20, 5'd8};   1401: cl = {8'h0E, 5'd10};
      1501: cl = {8'h0D, 5'd10};  1601: cl = {8'h08, 5'd10};
      1701: cl = {8'h1F, 5'd12};  1801: cl = {8'h1A, 5'd12};
      1901: cl = {8'h19, 5'd12};  2001: cl = {8'h17, 5'd12};
      2101: cl = {8'h16, 5'd12};  2201: cl = {8'h1F, 5'd13};
      2301: cl = {8'h1E, 5'd13};  2401: cl = {8'h1D, 5'd13};
      2501: cl = {8'h1C, 5'd13};  2601: cl = {8'h1B, 5'd13};
      default: cl = '0;
    endcase
    return cl;
  endfunction

  // Append count bits MSB-first; note the word that gets completed
  task automatic pack_bits(input logic [31:0] bits, input int count);
    logic [63:0] v;
    logic [63:0] sh;
    int total;
    int extra;
    v = {32'b0, bits} & ((64'd1 << count) - 64'd1);
    total = fill_m + count;
    if (total >= 32) begin
      extra = total - 32;
      sh = v >> extra;
      done_word = accum_m | sh[31:0];
      word_done = 1'b1;
      sh = v << (32 - extra);
      accum_m = (extra != 0) ? sh[31:0] : '0;
      fill_m = extra;
    end else begin
      sh = v << (32 - total);
      accum_m = accum_m | sh[31:0];
      fill_m = total;
    end
  endtask

  // Emit one nonzero level: table code plus sign, or the escape form
  task automatic code_level(input int amp);
    int mag;
    logic sign;
    logic [12:0] cl;
    logic [19:0] esc;
    logic [5:0] run6;
    logic [7:0] amp8;
    mag = (amp < 0) ? -amp : amp;
    sign = (amp < 0);
    cl = (mag <= 15) ? tcoeff_lookup(run_m, mag) : '0;
    if (cl[4:0] != '0) begin
      pack_bits({23'b0, cl[12:5], sign}, int'(cl[4:0]) + 1);
    end else begin
      run6 = run_m[5:0];
      amp8 = amp[7:0];
      esc = {ESC_PREFIX, run6, amp8};
      pack_bits({12'b0, esc}, ESC_W);
    end
  endtask

  // Advance the expected stream by one accepted beat
  task automatic encode_beat(input in_item_t b);
    int c;
    int t;
    int d;
    int amp;
    int mag;
    logic [THR_W-1:0] thr;
    out_item_t e;
    word_done = 1'b0;
    if (b.opcode == OP_FLUSH) begin
      e.word = accum_m;
      e.valid_bits = fill_m[VBITS_W-1:0];
      e.from_flush = 1'b1;
      expected_words.push_back(e);
      accum_m = '0;
      fill_m = 0;
      return;
    end
    c = $signed(b.coef);
    if (pos_m == 0) begin
      // DC: round, clamp to 1..254, and replace 128 by 255
      t = c + 4;
      d = (t < 0) ? 0 : (t >> 3);
      if (d <= 0) d = 1;
      else if (d > 254) d = 254;
      else if (d == 128) d = 255;
      pack_bits(d, int'(DC_LEN));
      run_m = 0;
      pos_m = 1;
    end else begin
      amp = c & 255;
      if (amp >= 128) amp -= 256;
      mag = (c < 0) ? -c : c;
      thr = b.is_chroma ? chroma_thr_m : luma_thr_m;
      if (pos_m >= int'(fstart_m) && mag <= int'(thr)) amp = 0;
      if (amp != 0) begin
        code_level(amp);
        run_m = 0;
      end else begin
        run_m = (run_m + 1) & 63;
      end
      if (pos_m >= int'(LAST_POS)) begin
        pack_bits({30'b0, EOB_CODE}, int'(EOB_LEN));
        pos_m = 0;
        run_m = 0;
      end else begin
        pos_m++;
      end
    end
    if (word_done) begin
      e.word = done_word;
      e.valid_bits = 6'd32;
      e.from_flush = 1'b0;
      expected_words.push_back(e);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t ns: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    error_count++;
  endtask

  // Compare every output beat against the oldest expected word; count input stalls
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_ready) input_stall_cycles++;
    if (rst_n && out_valid && out_ready) begin
      words_checked++;
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", '0, out_data.word);
      end else begin
        next_word = expected_words.pop_front();
        if (out_data.word !== next_word.word)
          report_mismatch("word", next_word.word, out_data.word);
        if (out_data.valid_bits !== next_word.valid_bits)
          report_mismatch("valid_bits", {26'b0, next_word.valid_bits},
                          {26'b0, out_data.valid_bits});
        if (out_data.from_flush !== next_word.from_flush)
          report_mismatch("from_flush", {31'b0, next_word.from_flush},
                          {31'b0, out_data.from_flush});
      end
    end
  end

  // Output side: stall a random count before each beat, or a long hold on request
  initial begin : word_sink
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold > 0) begin
        stall = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Offer one beat after a random gap and hold it until accepted
  task automatic send_beat(input in_item_t b);
    int gap;
    gap = (tx_burst || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    encode_beat(b);
    beats_sent++;
    if (b.opcode == OP_FLUSH) flushes_sent++;
  endtask

  task automatic send_flush();
    in_item_t b;
    logic [31:0] r;
    r = $urandom();
    b.opcode = OP_FLUSH;
    b.coef = r[11:0];
    b.is_chroma = r[12];
    send_beat(b);
  endtask

  // Drop valid, wait for every expected word, then let in-flight beats settle
  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk) in_valid <= 1'b0;
    while (expected_words.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_words.size() != 0) begin
      report_mismatch("words never delivered", 32'(expected_words.size()), '0);
      expected_words.delete();
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_LUMA_THR:     luma_thr_m = val;
      REG_CHROMA_THR:   chroma_thr_m = val;
      REG_FILTER_START: fstart_m = val[POS_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk) cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] luma, input logic [7:0] chroma,
                            input logic [7:0] fstart);
    write_reg(REG_LUMA_THR, luma);
    write_reg(REG_CHROMA_THR, chroma);
    write_reg(REG_FILTER_START, fstart);
  endtask

  // DC values around the rounding, clamp and 128 substitution points
  function automatic logic [11:0] pick_dc();
    logic [31:0] r;
    logic [11:0] v;
    r = $urandom();
    case ($urandom_range(0, 11))
      0: v = 12'h800;
      1: v = -12'sd5;
      2: v = 12'sd3;
      3: v = 12'sd4;
      4: v = 12'sd1019;
      5: v = 12'sd1020;
      6: v = 12'sd1027;
      7: v = 12'sd1028;
      8: v = 12'sd2028;
      9: v = 12'sd2047;
      default: v = r[11:0];
    endcase
    return v;
  endfunction

  function automatic logic [11:0] pick_ac(input coef_mix_t mix);
    int v;
    int sel;
    logic [31:0] r;
    r = $urandom();
    sel = $urandom_range(0, 99);
    if (mix == MIX_ESCAPES) v = $urandom_range(16, 127);
    else if (sel < 45) v = 0;
    else if (sel < 75) v = $urandom_range(1, 15);
    else if (sel < 85) v = $urandom_range(16, 127);
    else if (sel < 90) v = 256 * $urandom_range(1, 8);
    else if (sel < 95) v = int'(r[10:0]);
    else v = 2047;
    if ($urandom_range(0, 1) == 1) v = -v;
    if (mix == MIX_TYPICAL && sel >= 95 && sel < 97) v = -2048;
    return v[11:0];
  endfunction

  // One well-formed block with random content; occasional flushes and
  // chroma flips thrown in as noise
  task automatic send_block(input logic chroma, input coef_mix_t mix);
    in_item_t b;
    for (int pos = 0; pos < 64; pos++) begin
      if ($urandom_range(0, 24) == 0) send_flush();
      b.opcode = OP_COEF;
      b.coef = (pos == 0) ? pick_dc() : pick_ac(mix);
      b.is_chroma = ($urandom_range(0, 19) == 0) ? ~chroma : chroma;
      send_beat(b);
    end
  endtask

  // Hand-picked block under reset settings: table edges, escapes, truncation,
  // filtering on both components, a long run, and a flush mid-block
  task automatic test_directed_block();
    logic [11:0] coefs [64];
    logic        chroma [64];
    in_item_t    b;
    for (int i = 0; i < 64; i++) begin
      coefs[i] = '0;
      chroma[i] = 1'b0;
    end
    coefs[0]  = 12'sd1020;
    coefs[1]  = 12'sd1;
    coefs[2]  = -12'sd1;
    coefs[3]  = 12'sd15;
    coefs[4]  = -12'sd15;
    coefs[5]  = 12'sd16;
    coefs[6]  = -12'sd128;
    coefs[7]  = 12'sd127;
    coefs[8]  = 12'sd256;
    coefs[9]  = 12'h800;
    coefs[10] = 12'sd2047;
    coefs[11] = -12'sd129;
    coefs[12] = 12'sd255;
    coefs[20] = 12'sd1;
    coefs[21] = -12'sd2;
    coefs[22] = 12'sd2;
    chroma[22] = 1'b1;
    coefs[23] = -12'sd3;
    chroma[23] = 1'b1;
    coefs[60] = 12'sd3;
    coefs[61] = -12'sd1;
    coefs[62] = 12'sd4;
    coefs[63] = -12'sd1;
    for (int i = 0; i < 64; i++) begin
      if (i == 12) send_flush();
      b.opcode = OP_COEF;
      b.coef = coefs[i];
      b.is_chroma = chroma[i];
      send_beat(b);
    end
  endtask

  // Partial-word flush followed by a flush of an empty packer
  task automatic test_flush_edges();
    send_flush();
    send_flush();
    wait_drained();
  endtask

  // Threshold and filter-start extremes, masked values and the unused index
  task automatic test_register_extremes();
    logic [31:0] r;
    set_config(8'd0, 8'd0, 8'd1);
    send_block(1'b0, MIX_TYPICAL);
    wait_drained();
    set_config(8'd255, 8'd255, 8'hFF);
    send_block(1'b1, MIX_TYPICAL);
    wait_drained();
    r = $urandom();
    set_config(8'h80, 8'h7F, 8'hC0);
    write_reg(REG_UNUSED, r[7:0]);
    send_block(r[8], MIX_TYPICAL);
    wait_drained();
  endtask

  // Hold the output off for a long stretch while input streams at full rate
  task automatic test_backpressure();
    set_config(8'd1, 8'd2, 8'd20);
    tx_burst = 1'b1;
    rx_hold = 300;
    send_block(1'b0, MIX_ESCAPES);
    send_block(1'b1, MIX_ESCAPES);
    tx_burst = 1'b0;
    wait_drained();
  endtask

  // Random blocks with random settings and idle modes; pause once to drain
  task automatic test_random_blocks();
    int start_count;
    bit paused;
    logic [31:0] r;
    start_count = beats_sent;
    paused = 1'b0;
    while (beats_sent - start_count < 100) begin
      r = $urandom();
      if (r[1:0] == 2'd0) begin
        wait_drained();
        set_config(r[15:8], r[23:16], r[31:24]);
      end
      tx_burst = (r[3:2] == 2'd0);
      rx_burst = (r[5:4] == 2'd0);
      send_block(r[6], MIX_TYPICAL);
      if (!paused && beats_sent - start_count >= 50) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    send_flush();
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_directed_block();
    test_flush_edges();
    test_register_extremes();
    test_backpressure();
    test_random_blocks();
    wait_drained();
    $display("Sent %0d beats (%0d flushes) over %0d register writes; checked %0d words.",
             beats_sent, flushes_sent, reg_writes, words_checked);
    $display("Input was held off for %0d cycles by output backpressure.",
             input_stall_cycles);
    if (error_count == 0) begin
      $display("tb_dct_coef_runlength_vlc_encoder: clean");
    end else begin
      $display("tb_dct_coef_runlength_vlc_encoder: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Run did not finish in time.");
    $display("tb_dct_coef_runlength_vlc_encoder: errors");
    $finish;
  end

endmodule
